// ===== src/assert_macros.svh =====
// Shared assertion macros for the gradient mapper checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked concurrent assertion, disabled during reset.
`define GMC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked concurrent assertion that also holds during reset.
`define GMC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/gmmcg_pkg.sv =====
package gmmcg_pkg;

  localparam int MAX_WIDTH     = 512;
  localparam int MAX_HEIGHT    = 256;
  localparam int FRACTION_BITS = 16;

  localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int PTR_W  = $clog2(CELLS + 1);

  localparam int SAMPLE_W = 32;
  localparam int COLOR_W  = 8;
  localparam int WIDTH_W  = 10;
  localparam int HEIGHT_W = 9;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // no-data level in tenths: 99999 * 2^FRACTION_BITS
  localparam longint NO_DATA_TENTHS = 64'd99999 << FRACTION_BITS;
  localparam longint MIN_START_FULL = NO_DATA_TENTHS / 10;
  localparam logic [SAMPLE_W-1:0] MIN_START =
    (MIN_START_FULL > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : MIN_START_FULL[SAMPLE_W-1:0];

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_RED     = 3'd0,
    REG_LOW_GREEN   = 3'd1,
    REG_LOW_BLUE    = 3'd2,
    REG_HIGH_RED    = 3'd3,
    REG_HIGH_GREEN  = 3'd4,
    REG_HIGH_BLUE   = 3'd5,
    REG_GRID_WIDTH  = 3'd6,
    REG_GRID_HEIGHT = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic                       kind;
    logic                       first;
    logic signed [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               draw;
    logic               last;
  } out_word_t;

endpackage

// ===== src/grid_min_max_color_gradient.sv =====
// Two-color gradient mapper. A load word stores one Q15.16 sample in the
// on-chip sample memory (512 x 256 words, no clearing pass) and updates the
// running minimum and maximum; loads stream at one per cycle while no emit is
// in progress. An emit word reads the next sample back from a registered
// memory read, normalizes it against the min/max range and blends the two
// colors through the 8-step restoring divider that forms each channel exactly;
// no further word is taken until its pixel is in the output register. The
// finished pixel waits there, so loads are taken while it is stalled. The user
// is to write configuration only while the block is idle; it is not enforced.
module grid_min_max_color_gradient (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  gmmcg_pkg::in_word_t                  in_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output gmmcg_pkg::out_word_t                 out_word,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gmmcg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmmcg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW   = gmmcg_pkg::SAMPLE_W;
  localparam int CW   = gmmcg_pkg::COLOR_W;
  localparam int RW   = SW + 1;          // magnitude of range
  localparam int PW   = RW + CW;         // one product
  localparam int NW   = PW + 1;          // sum of products
  localparam int DIVN = CW;              // quotient bits

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MUL, S_SUM, S_DIV, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [CW-1:0] low_c  [3];
  logic [CW-1:0] high_c [3];
  logic [gmmcg_pkg::WIDTH_W-1:0]  grid_width;
  logic [gmmcg_pkg::HEIGHT_W-1:0] grid_height;

  // frame state
  logic [gmmcg_pkg::PTR_W-1:0] load_pointer, emit_pointer;
  logic [gmmcg_pkg::COL_W-1:0] emit_column;
  logic [gmmcg_pkg::ROW_W-1:0] emit_row;
  logic signed [SW-1:0] running_min, running_max;

  // sample memory
  logic [SW-1:0] mem [gmmcg_pkg::CELLS];
  logic [SW-1:0] rd_data;
  logic wr_en, rd_en;

  // datapath
  logic [RW-1:0] rr, diff, dd;
  logic          draw_r;
  logic [PW-1:0] prod_lo [3];
  logic [PW-1:0] prod_hi [3];
  logic [NW-1:0] rem [3];
  logic [NW-1:0] dsr;
  logic [DIVN-1:0] quo [3];
  logic [2:0] cnt;
  logic [gmmcg_pkg::COL_W-1:0] col_r;
  logic [gmmcg_pkg::ROW_W-1:0] row_r;
  logic last_r;

  // effective dimensions
  logic [gmmcg_pkg::WIDTH_W-1:0]  eff_w;
  logic [gmmcg_pkg::HEIGHT_W-1:0] eff_h;
  logic [gmmcg_pkg::PTR_W-1:0]    cells;

  always_comb begin
    if (grid_width == '0) begin
      eff_w = gmmcg_pkg::WIDTH_W'(1);
    end else if (grid_width > gmmcg_pkg::WIDTH_W'(gmmcg_pkg::MAX_WIDTH)) begin
      eff_w = gmmcg_pkg::WIDTH_W'(gmmcg_pkg::MAX_WIDTH);
    end else begin
      eff_w = grid_width;
    end
    if (grid_height == '0) begin
      eff_h = gmmcg_pkg::HEIGHT_W'(1);
    end else if (grid_height > gmmcg_pkg::HEIGHT_W'(gmmcg_pkg::MAX_HEIGHT)) begin
      eff_h = gmmcg_pkg::HEIGHT_W'(gmmcg_pkg::MAX_HEIGHT);
    end else begin
      eff_h = grid_height;
    end
    cells = gmmcg_pkg::PTR_W'(eff_w) * gmmcg_pkg::PTR_W'(eff_h);
  end

  function automatic logic is_data(input logic [SW-1:0] s);
    logic signed [47:0] sx;
    logic signed [47:0] t;
    sx = 48'(signed'(s));
    t = (sx <<< 3) + (sx <<< 1) + 48'(gmmcg_pkg::NO_DATA_TENTHS);
    return t > 48'sd0;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  logic accept, acc_load, acc_emit;
  assign accept   = in_valid && !in_stall;
  assign acc_load = accept && (in_word.kind == gmmcg_pkg::KIND_LOAD);
  assign acc_emit = accept && (in_word.kind == gmmcg_pkg::KIND_EMIT) &&
                    (emit_pointer < cells);

  // output register takes a new pixel when it is empty or being drained
  logic out_load;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);

  // load path: pointers and extremes as seen after an optional frame restart
  logic [gmmcg_pkg::PTR_W-1:0] lp_eff;
  logic signed [SW-1:0] min_eff, max_eff;
  assign lp_eff  = in_word.first ? '0 : load_pointer;
  assign min_eff = in_word.first ? signed'(gmmcg_pkg::MIN_START) : running_min;
  assign max_eff = in_word.first ? '0 : running_max;
  assign wr_en   = acc_load && (lp_eff < cells);
  assign rd_en   = acc_emit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[lp_eff[gmmcg_pkg::ADDR_W-1:0]] <= in_word.sample;
    end
    if (rd_en) begin
      rd_data <= mem[emit_pointer[gmmcg_pkg::ADDR_W-1:0]];
    end
  end

  // prepare range and clamped offset
  logic signed [SW+1:0] d34, r34, dn, rn;
  always_comb begin
    d34 = (SW+2)'(signed'(rd_data)) - (SW+2)'(running_min);
    r34 = (SW+2)'(running_max) - (SW+2)'(running_min);
    if (r34 < 0) begin
      rn = -r34;
      dn = -d34;
    end else begin
      rn = r34;
      dn = d34;
    end
    if (rn == 0) begin
      rn = (SW+2)'(1);
      dn = '0;
    end
    if (dn < 0) begin
      dn = '0;
    end
    if (dn > rn) begin
      dn = rn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      low_c[0]     <= 8'd0;
      low_c[1]     <= 8'd255;
      low_c[2]     <= 8'd0;
      high_c[0]    <= 8'd255;
      high_c[1]    <= 8'd0;
      high_c[2]    <= 8'd0;
      grid_width   <= 10'd325;
      grid_height  <= 9'd170;
      load_pointer <= '0;
      emit_pointer <= '0;
      emit_column  <= '0;
      emit_row     <= 8'd169;
      running_min  <= signed'(gmmcg_pkg::MIN_START);
      running_max  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (gmmcg_pkg::reg_index_t'(cfg_index))
          gmmcg_pkg::REG_LOW_RED:     low_c[0]    <= cfg_data[CW-1:0];
          gmmcg_pkg::REG_LOW_GREEN:   low_c[1]    <= cfg_data[CW-1:0];
          gmmcg_pkg::REG_LOW_BLUE:    low_c[2]    <= cfg_data[CW-1:0];
          gmmcg_pkg::REG_HIGH_RED:    high_c[0]   <= cfg_data[CW-1:0];
          gmmcg_pkg::REG_HIGH_GREEN:  high_c[1]   <= cfg_data[CW-1:0];
          gmmcg_pkg::REG_HIGH_BLUE:   high_c[2]   <= cfg_data[CW-1:0];
          gmmcg_pkg::REG_GRID_WIDTH:  grid_width  <= cfg_data[gmmcg_pkg::WIDTH_W-1:0];
          gmmcg_pkg::REG_GRID_HEIGHT: grid_height <= cfg_data[gmmcg_pkg::HEIGHT_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (acc_load) begin
            if (in_word.first) begin
              emit_pointer <= '0;
              emit_column  <= '0;
              emit_row     <= gmmcg_pkg::ROW_W'(eff_h - 1'b1);
            end
            // a restart always lands inside the grid, so this also clears
            if (lp_eff < cells) begin
              load_pointer <= lp_eff + 1'b1;
              if (in_word.sample > max_eff) begin
                running_max <= in_word.sample;
              end else begin
                running_max <= max_eff;
              end
              if (is_data(in_word.sample) && in_word.sample < min_eff) begin
                running_min <= in_word.sample;
              end else begin
                running_min <= min_eff;
              end
            end
          end else if (acc_emit) begin
            col_r  <= emit_column;
            row_r  <= emit_row;
            last_r <= (emit_pointer == cells - 1'b1);
            emit_pointer <= emit_pointer + 1'b1;
            if ({1'b0, emit_column} + 1'b1 >= eff_w) begin
              emit_column <= '0;
              emit_row    <= emit_row - 1'b1;
            end else begin
              emit_column <= emit_column + 1'b1;
            end
            state <= S_PREP;
          end
        end
        S_PREP: begin
          draw_r <= is_data(rd_data);
          rr     <= rn[RW-1:0];
          dd     <= dn[RW-1:0];
          diff   <= rn[RW-1:0] - dn[RW-1:0];
          state  <= S_MUL;
        end
        S_MUL: begin
          for (int c = 0; c < 3; c++) begin
            prod_lo[c] <= PW'(low_c[c]) * PW'(diff);
            prod_hi[c] <= PW'(high_c[c]) * PW'(dd);
          end
          state <= S_SUM;
        end
        S_SUM: begin
          for (int c = 0; c < 3; c++) begin
            rem[c] <= NW'(prod_lo[c]) + NW'(prod_hi[c]);
            quo[c] <= '0;
          end
          dsr   <= NW'(rr) << (DIVN - 1);
          cnt   <= 3'(DIVN - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          // one quotient bit per channel; result is known to fit in 8 bits
          for (int c = 0; c < 3; c++) begin
            if (rem[c] >= dsr) begin
              rem[c] <= rem[c] - dsr;
              quo[c] <= {quo[c][DIVN-2:0], 1'b1};
            end else begin
              quo[c] <= {quo[c][DIVN-2:0], 1'b0};
            end
          end
          dsr <= dsr >> 1;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            out_word.column <= col_r;
            out_word.row    <= row_r;
            out_word.red    <= draw_r ? quo[0] : '0;
            out_word.green  <= draw_r ? quo[1] : '0;
            out_word.blue   <= draw_r ? quo[2] : '0;
            out_word.draw   <= draw_r;
            out_word.last   <= last_r;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/gmmcg_checker.sv =====
`include "assert_macros.svh"

module gmmcg_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input gmmcg_pkg::in_word_t  in_word,
  input logic                 out_valid,
  input logic                 out_stall,
  input gmmcg_pkg::out_word_t out_word
);

  `GMC_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "output word dropped while stalled")
  `GMC_ASSERT(a_load_silent, clk, rst, in_valid && !in_stall && in_word.kind == gmmcg_pkg::KIND_LOAD && !out_valid |=> !out_valid, "load produced a word")
  `GMC_ASSERT(a_nodraw_black, clk, rst, out_valid && !out_word.draw |-> out_word.red == '0 && out_word.green == '0 && out_word.blue == '0, "undrawn pixel has color")
  `GMC_ASSERT(a_busy_before_out, clk, rst, $rose(out_valid) |-> $past(in_stall), "result appeared without busy phase")

endmodule

bind grid_min_max_color_gradient gmmcg_checker u_gmmcg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 50000;
  localparam int NO_DATA_MAX   = -655353447;  // largest no-data sample
  localparam int MIN_START_I   = 655353446;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  gmmcg_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gmmcg_pkg::out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gmmcg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [gmmcg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  grid_min_max_color_gradient i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mapper state mirror
  logic signed [31:0] grid_mem [gmmcg_pkg::CELLS];
  bit written_cell [gmmcg_pkg::CELLS];
  int unsigned load_ptr, emit_ptr, emit_col, emit_row;
  int signed run_min, run_max;
  int unsigned color_lo [3];
  int unsigned color_hi [3];
  int unsigned width_reg, height_reg;

  gmmcg_pkg::out_word_t expected_pixels [$];
  int mismatches = 0;
  int words_sent = 0;
  int hold_cycles = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int signed frame_base;

  function automatic int unsigned grid_w();
    return (width_reg == 0) ? 1 :
           (width_reg > gmmcg_pkg::MAX_WIDTH) ? gmmcg_pkg::MAX_WIDTH : width_reg;
  endfunction

  function automatic int unsigned grid_h();
    return (height_reg == 0) ? 1 :
           (height_reg > gmmcg_pkg::MAX_HEIGHT) ? gmmcg_pkg::MAX_HEIGHT : height_reg;
  endfunction

  function automatic bit has_data(int signed s);
    return longint'(s) * 10 + (longint'(99999) << gmmcg_pkg::FRACTION_BITS) > 0;
  endfunction

  function automatic logic [7:0] mix_channel(int unsigned lo, int unsigned hi,
                                             longint d, longint r);
    longint unsigned num;
    if (r == 0) return lo[7:0];
    if (r < 0) begin
      r = -r;
      d = -d;
    end
    if (d < 0) d = 0;
    if (d > r) d = r;
    num = longint'(lo) * (r - d) + longint'(hi) * d;
    return 8'(num / r);
  endfunction

  task automatic reset_mirror();
    color_lo = '{0, 255, 0};
    color_hi = '{255, 0, 0};
    width_reg = 325;
    height_reg = 170;
    load_ptr = 0;
    emit_ptr = 0;
    emit_col = 0;
    emit_row = (grid_h() - 1) & 8'hFF;
    run_min = MIN_START_I;
    run_max = 0;
  endtask

  task automatic predict_pixel(gmmcg_pkg::in_word_t w);
    int unsigned cells;
    gmmcg_pkg::out_word_t px;
    int signed v;
    longint d, r;
    cells = grid_w() * grid_h();
    if (w.kind == gmmcg_pkg::KIND_LOAD) begin
      if (w.first) begin
        load_ptr = 0;
        emit_ptr = 0;
        emit_col = 0;
        emit_row = (grid_h() - 1) & 8'hFF;
        run_min = MIN_START_I;
        run_max = 0;
      end
      if (load_ptr < cells) begin
        grid_mem[load_ptr] = w.sample;
        written_cell[load_ptr] = 1'b1;
        load_ptr++;
        if (w.sample > run_max) run_max = w.sample;
        if (has_data(w.sample) && w.sample < run_min) run_min = w.sample;
      end
    end else if (emit_ptr < cells) begin
      v = grid_mem[emit_ptr];
      d = longint'(v) - longint'(run_min);
      r = longint'(run_max) - longint'(run_min);
      px.column = emit_col[8:0];
      px.row = emit_row[7:0];
      px.draw = has_data(v);
      px.red = px.draw ? mix_channel(color_lo[0], color_hi[0], d, r) : 8'd0;
      px.green = px.draw ? mix_channel(color_lo[1], color_hi[1], d, r) : 8'd0;
      px.blue = px.draw ? mix_channel(color_lo[2], color_hi[2], d, r) : 8'd0;
      px.last = (emit_ptr == cells - 1);
      expected_pixels.push_back(px);
      emit_ptr++;
      if (emit_col + 1 >= grid_w()) begin
        emit_col = 0;
        emit_row = (emit_row - 1) & 8'hFF;
      end else begin
        emit_col++;
      end
    end
  endtask

  // sender: hold valid across back-to-back words, drop it on a gap
  task automatic send_word(logic kind, logic first, logic signed [31:0] sample);
    gmmcg_pkg::in_word_t w;
    w.kind = kind;
    w.first = first;
    w.sample = sample;
    @(negedge clk);
    in_valid = 1'b1;
    in_word = w;
    do @(posedge clk); while (in_stall);
    predict_pixel(w);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 2) != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_pixels.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(gmmcg_pkg::reg_index_t idx, int unsigned value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value[gmmcg_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      gmmcg_pkg::REG_GRID_WIDTH:  width_reg = value & 10'h3FF;
      gmmcg_pkg::REG_GRID_HEIGHT: height_reg = value & 9'h1FF;
      gmmcg_pkg::REG_LOW_RED, gmmcg_pkg::REG_LOW_GREEN, gmmcg_pkg::REG_LOW_BLUE:
        color_lo[idx] = value & 8'hFF;
      default: color_hi[idx - gmmcg_pkg::REG_HIGH_RED] = value & 8'hFF;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_grid(int unsigned w, int unsigned h);
    write_reg(gmmcg_pkg::REG_GRID_WIDTH, w);
    write_reg(gmmcg_pkg::REG_GRID_HEIGHT, h);
  endtask

  task automatic set_colors(int unsigned lr, int unsigned lg, int unsigned lb,
                            int unsigned hr, int unsigned hg, int unsigned hb);
    write_reg(gmmcg_pkg::REG_LOW_RED, lr);
    write_reg(gmmcg_pkg::REG_LOW_GREEN, lg);
    write_reg(gmmcg_pkg::REG_LOW_BLUE, lb);
    write_reg(gmmcg_pkg::REG_HIGH_RED, hr);
    write_reg(gmmcg_pkg::REG_HIGH_GREEN, hg);
    write_reg(gmmcg_pkg::REG_HIGH_BLUE, hb);
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? NO_DATA_MAX : NO_DATA_MAX + 1;
      2: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      3: return $urandom_range(0, 1) ? MIN_START_I : MIN_START_I + 1;
      4: return frame_base - $urandom_range(0, 1 << 24);
      default: return frame_base + $urandom_range(0, 1 << $urandom_range(4, 22));
    endcase
  endfunction

  // emit only where the cell behind the pointer holds a loaded sample or the pointer is past the grid
  task automatic send_emit_or_load();
    if (emit_ptr >= grid_w() * grid_h() || written_cell[emit_ptr])
      send_word(gmmcg_pkg::KIND_EMIT, $urandom_range(0, 1), $urandom);
    else
      send_word(gmmcg_pkg::KIND_LOAD, 1'b0, rand_sample());
  endtask

  task automatic load_frame(int unsigned extra);
    int unsigned cells;
    cells = grid_w() * grid_h();
    send_word(gmmcg_pkg::KIND_LOAD, 1'b1, rand_sample());
    for (int unsigned i = 1; i < cells + extra; i++)
      send_word(gmmcg_pkg::KIND_LOAD, 1'b0, rand_sample());
  endtask

  task automatic emit_frame(int unsigned extra);
    int unsigned cells;
    cells = grid_w() * grid_h();
    for (int unsigned i = 0; i < cells + extra; i++)
      send_word(gmmcg_pkg::KIND_EMIT, i[0], $urandom);
  endtask

  task automatic test_directed();
    frame_base = 1000;
    set_colors(0, 255, 0, 255, 0, 0);
    set_grid(2, 2);
    // extremes and both no-data boundaries in one grid
    send_word(gmmcg_pkg::KIND_LOAD, 1'b1, 32'sh7FFF_FFFF);
    send_word(gmmcg_pkg::KIND_LOAD, 1'b0, 32'sh8000_0000);
    send_word(gmmcg_pkg::KIND_LOAD, 1'b0, NO_DATA_MAX);
    send_word(gmmcg_pkg::KIND_LOAD, 1'b0, NO_DATA_MAX + 1);
    send_word(gmmcg_pkg::KIND_LOAD, 1'b0, 32'sd5);   // past the grid: dropped
    emit_frame(2);                                  // two emits past the end
    drain();
    set_colors(255, 0, 255, 0, 255, 255);
    // all samples equal: zero range
    send_word(gmmcg_pkg::KIND_LOAD, 1'b1, 32'sd77);
    repeat (3) send_word(gmmcg_pkg::KIND_LOAD, 1'b0, 32'sd77);
    emit_frame(0);
    // no-data first load leaves max below min; older cells read back
    send_word(gmmcg_pkg::KIND_LOAD, 1'b1, NO_DATA_MAX);
    emit_frame(0);
    drain();
    // change the grid mid-frame so the row wraps
    send_word(gmmcg_pkg::KIND_LOAD, 1'b1, 32'sd100);
    repeat (3) send_word(gmmcg_pkg::KIND_LOAD, 1'b0, 32'sd300);
    drain();
    set_grid(1, 4);
    emit_frame(1);
    drain();
  endtask

  task automatic test_dimension_extremes();
    int unsigned dims [4][2];
    dims = '{'{0, 3}, '{3, 0}, '{1023, 1}, '{1, 511}};
    foreach (dims[k]) begin
      set_grid(dims[k][0], dims[k][1]);
      frame_base = $urandom_range(0, 1 << 20);
      load_frame(1);
      emit_frame(1);
      drain();
    end
  endtask

  task automatic test_backpressure();
    set_grid(4, 3);
    frame_base = -5000;
    hold_cycles = 600;
    load_frame(0);
    emit_frame(0);
    load_frame(0);
    drain();
  endtask

  task automatic test_random_frames();
    while (words_sent < 1750) begin
      set_colors($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
      set_grid($urandom_range(1, 12), $urandom_range(1, 6));
      frame_base = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 22);
      if ($urandom_range(0, 4) != 0) begin
        load_frame($urandom_range(0, 3) == 0);
        emit_frame($urandom_range(0, 3) == 0);
      end else begin
        repeat ($urandom_range(5, 40))
          if ($urandom_range(0, 1))
            send_word(gmmcg_pkg::KIND_LOAD, $urandom_range(0, 7) == 0, rand_sample());
          else
            send_emit_or_load();
      end
      drain();
    end
  endtask

  // receiver: long hold-off when asked, otherwise a shifting stall pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase++;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else begin
      case ((stall_phase / 97) % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %p", out_word);
      end else begin
        if (out_word !== expected_pixels[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected %p, got %p", expected_pixels[0], out_word);
        end
        void'(expected_pixels.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || expected_pixels.size() == 0 && !in_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    reset_mirror();
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_dimension_extremes();
    test_backpressure();
    test_random_frames();
    drain();
    if (mismatches == 0 && expected_pixels.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/gmmcg_pkg.sv
src/grid_min_max_color_gradient.sv
src/gmmcg_checker.sv
tb/testbench.sv
